[hw/rtl/conv3_pkg.sv]
// shared types and constants of the 3x3 convolution core
package conv3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int DIM_W   = 11;                          // frame size register width
	localparam int PIX_W   = 24;                          // three 8-bit channels
	localparam int KROW_W  = 24;                          // three signed 8-bit coefficients
	localparam int SHIFT_W = 3;
	localparam int XI_W    = $clog2(MAX_WIDTH);           // line store address
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);      // runs past the height while draining
	localparam int OROW_W  = $clog2(MAX_HEIGHT + 1);
	localparam int CMP_W   = 16;                          // common width for counter compares

	localparam int PROD_W  = 17;
	localparam int SUM_W   = 21;

	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
	localparam int OUT_DEPTH = 8;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);

	localparam logic OPC_PIXEL = 1'b0;
	localparam logic OPC_DRAIN = 1'b1;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_KTOP   = 3'd2,
		REG_KMID   = 3'd3,
		REG_KBOT   = 3'd4,
		REG_SHIFT  = 3'd5
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [DIM_W-1:0]           width;
		logic [DIM_W-1:0]           height;
		logic [2:0][KROW_W-1:0]     kernel;  // [0] top, [1] middle, [2] bottom
		logic [SHIFT_W-1:0]         shift;
	} cfg_t;

	// one window step handed from the front to the back
	typedef struct packed {
		pix_t            pix;
		logic [XI_W-1:0] xi;
		logic            first;  // column zero: window restarts
		logic            emit;   // this step yields an output
		logic            top;    // output row is the first one
		logic            bot;    // output row is the last one
		logic            last;   // last output of the frame
	} op_t;

	typedef struct packed {
		logic last;
		pix_t pix;
	} out_t;

endpackage

[hw/rtl/convolution_3x3_clamped_edges_core.sv]
// top level of the 3x3 RGB convolution core with replicated borders
//
// Filters an RGB pixel stream in raster order with a programmable signed 3x3
// kernel shared by all channels; pixels outside the frame repeat the nearest edge pixel.
// Each weighted sum is shifted right by coefficient_shift and clamped to
// 0..255. Output pixel k leaves once input pixel k + width + 1 has come in, so
// at the end of a frame the user sends drain transactions (tuser = 1), one per
// pending output, and the last output carries tlast. The core takes one pixel
// per clock while its step queue is not full; the other exception is the first
// drain of a one-row frame, which holds tready low while a second step issues.
// Rate is set by the two line stores, each read and written once per pixel at
// the current column; results pass stages s1 to s4 and a result buffer. The user
// must write configuration only between frames while the core is idle; the core does not enforce it.
module convolution_3x3_clamped_edges_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_wdata,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
	input  logic        s_axis_tuser,   // opcode

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
	output logic        m_axis_tlast    // frame_end
);

	conv3_pkg::cfg_t  cfg_q;

	// front to queue and queue to back
	logic             op_push, op_full, op_pop, op_empty;
	conv3_pkg::op_t   op_wdata, op_rdata;
	conv3_pkg::out_t  res;

	// configuration registers, reset to an identity kernel at full size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width     <= conv3_pkg::DIM_W'(1024);
			cfg_q.height    <= conv3_pkg::DIM_W'(1024);
			cfg_q.kernel[0] <= '0;
			cfg_q.kernel[1] <= conv3_pkg::KROW_W'(256);
			cfg_q.kernel[2] <= '0;
			cfg_q.shift     <= '0;
		end else if (cfg_we) begin
			unique case (conv3_pkg::reg_idx_t'(cfg_index))
				conv3_pkg::REG_WIDTH:  cfg_q.width     <= cfg_wdata[conv3_pkg::DIM_W-1:0];
				conv3_pkg::REG_HEIGHT: cfg_q.height    <= cfg_wdata[conv3_pkg::DIM_W-1:0];
				conv3_pkg::REG_KTOP:   cfg_q.kernel[0] <= cfg_wdata;
				conv3_pkg::REG_KMID:   cfg_q.kernel[1] <= cfg_wdata;
				conv3_pkg::REG_KBOT:   cfg_q.kernel[2] <= cfg_wdata;
				conv3_pkg::REG_SHIFT:  cfg_q.shift     <= cfg_wdata[conv3_pkg::SHIFT_W-1:0];
				default: ;  // unused indexes are dropped
			endcase
		end
	end

	// front: tracks input and output position, turns transactions into steps
	conv3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tuser),
		.in_pix    (s_axis_tdata),
		.op_full   (op_full),
		.op_push   (op_push),
		.op_data   (op_wdata)
	);

	// decouples the front from back-pressure on the result side
	conv3_op_fifo u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_wdata),
		.full   (op_full),
		.pop    (op_pop),
		.empty  (op_empty),
		.rdata  (op_rdata)
	);

	// back: line stores, window, kernel arithmetic, result buffer
	conv3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.op_empty  (op_empty),
		.op_data   (op_rdata),
		.op_pop    (op_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = res.pix;
	assign m_axis_tlast = res.last;

`ifndef SYNTH
	// the front never overruns the step queue
	assert property (@(posedge clk) disable iff (!arst_n) op_push |-> !op_full)
		else $error("step queue overrun");
	// the back never takes a step that is not there
	assert property (@(posedge clk) disable iff (!arst_n) op_pop |-> !op_empty)
		else $error("step queue underrun");
	// no input transaction while the queue is full
	assert property (@(posedge clk) disable iff (!arst_n) op_full |-> !s_axis_tready)
		else $error("input taken with full queue");
`endif

endmodule

[hw/rtl/conv3_op_fifo.sv]
// small queue of window steps between front and back
module conv3_op_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  conv3_pkg::op_t  wdata,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output conv3_pkg::op_t  rdata
);

	conv3_pkg::op_t                  mem_q [conv3_pkg::OPQ_DEPTH];
	logic [conv3_pkg::OPQ_AW-1:0]    wr_ptr_q;
	logic [conv3_pkg::OPQ_AW-1:0]    rd_ptr_q;
	logic [conv3_pkg::OPQ_AW:0]      cnt_q;

	assign full  = (cnt_q == (conv3_pkg::OPQ_AW+1)'(conv3_pkg::OPQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[hw/rtl/conv3_front.sv]
// input side: position tracking, drain handling and step issue
module conv3_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  conv3_pkg::cfg_t         cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_opcode,
	input  conv3_pkg::pix_t         in_pix,
	input  logic                    op_full,
	output logic                    op_push,
	output conv3_pkg::op_t          op_data
);

	logic [conv3_pkg::COL_W-1:0]  col_q;
	logic [conv3_pkg::ROW_W-1:0]  row_q;
	logic [conv3_pkg::COL_W-1:0]  ocol_q;
	logic [conv3_pkg::OROW_W-1:0] orow_q;
	logic                         second_q;

	logic [conv3_pkg::DIM_W-1:0]  w_used, h_used;
	logic complete, pending, adv_emit, out_ok, col_wrap, ocol_wrap, last;
	logic in_xfer, is_pix, drain_go, clear_only;

	always_comb begin
		if (cfg.width == '0)
			w_used = conv3_pkg::DIM_W'(1);
		else if (cfg.width > conv3_pkg::DIM_W'(conv3_pkg::MAX_WIDTH))
			w_used = conv3_pkg::DIM_W'(conv3_pkg::MAX_WIDTH);
		else
			w_used = cfg.width;
		if (cfg.height == '0)
			h_used = conv3_pkg::DIM_W'(1);
		else if (cfg.height > conv3_pkg::DIM_W'(conv3_pkg::MAX_HEIGHT))
			h_used = conv3_pkg::DIM_W'(conv3_pkg::MAX_HEIGHT);
		else
			h_used = cfg.height;
	end

	assign complete  = conv3_pkg::CMP_W'(row_q) >= conv3_pkg::CMP_W'(h_used);
	assign pending   = conv3_pkg::CMP_W'(orow_q) < conv3_pkg::CMP_W'(h_used);
	assign adv_emit  = (row_q >= conv3_pkg::ROW_W'(2))
		|| (row_q == conv3_pkg::ROW_W'(1) && col_q != '0);
	assign out_ok    = adv_emit && pending;
	assign col_wrap  = conv3_pkg::CMP_W'(col_q) + 1'b1 >= conv3_pkg::CMP_W'(w_used);
	assign ocol_wrap = conv3_pkg::CMP_W'(ocol_q) + 1'b1 >= conv3_pkg::CMP_W'(w_used);
	assign last      = ocol_wrap
		&& (conv3_pkg::CMP_W'(orow_q) + 1'b1 >= conv3_pkg::CMP_W'(h_used));

	assign in_ready   = !second_q && !op_full;
	assign in_xfer    = in_valid && in_ready;
	assign is_pix     = (in_opcode == conv3_pkg::OPC_PIXEL) && !complete;
	assign drain_go   = !is_pix && complete && pending;
	assign clear_only = in_xfer && !is_pix && complete && !pending;

	assign op_push = (in_xfer && (is_pix || drain_go)) || (second_q && !op_full);

	always_comb begin
		op_data.pix   = (in_xfer && is_pix) ? in_pix : '0;
		op_data.xi    = conv3_pkg::XI_W'(col_q);
		op_data.first = (col_q == '0);
		op_data.emit  = out_ok;
		op_data.top   = (orow_q == '0);
		op_data.bot   = conv3_pkg::CMP_W'(orow_q) + 1'b1 == conv3_pkg::CMP_W'(h_used);
		op_data.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			second_q <= 1'b0;
		end else begin
			if (op_push) begin
				if (out_ok && last) begin
					col_q  <= '0;
					row_q  <= '0;
					ocol_q <= '0;
					orow_q <= '0;
				end else begin
					if (col_wrap) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
					if (out_ok) begin
						if (ocol_wrap) begin
							ocol_q <= '0;
							orow_q <= orow_q + 1'b1;
						end else begin
							ocol_q <= ocol_q + 1'b1;
						end
					end
				end
			end else if (clear_only) begin
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end
			// first drain step gave nothing: one more step before the next item
			if (in_xfer && drain_go && !out_ok) second_q <= 1'b1;
			else if (second_q && !op_full)      second_q <= 1'b0;
		end
	end

endmodule

[hw/rtl/conv3_back.sv]
// line stores, 3x3 window, multiply-accumulate and result buffer
module conv3_back (
	input  logic                clk,
	input  logic                arst_n,
	input  conv3_pkg::cfg_t     cfg,
	input  logic                op_empty,
	input  conv3_pkg::op_t      op_data,
	output logic                op_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output conv3_pkg::out_t     out_data
);

	// line stores and their read data
	conv3_pkg::pix_t  upper_mem [conv3_pkg::MAX_WIDTH];
	conv3_pkg::pix_t  lower_mem [conv3_pkg::MAX_WIDTH];
	conv3_pkg::pix_t  up_rd_s1, lo_rd_s1;
	conv3_pkg::op_t   op_s1;
	logic             valid_s1;

	// last write, for a read that raced it
	logic [conv3_pkg::XI_W-1:0] wr_addr_q;
	conv3_pkg::pix_t            wr_up_q, wr_lo_q;
	logic                       wr_valid_q;

	conv3_pkg::pix_t  win_q [9];
	conv3_pkg::pix_t  win_d [9];
	conv3_pkg::pix_t  nb    [9];
	conv3_pkg::pix_t  col   [3];
	logic             fwd;

	conv3_pkg::pix_t  nb_s2 [9];
	logic             valid_s2, last_s2;

	logic signed [conv3_pkg::PROD_W-1:0] prod_s3 [3][9];
	logic                                valid_s3, last_s3;

	logic signed [conv3_pkg::SUM_W-1:0]  sum_d  [3];
	logic signed [conv3_pkg::SUM_W-1:0]  sum_s4 [3];
	logic                                valid_s4, last_s4;

	conv3_pkg::out_t                     res;
	logic [conv3_pkg::SUM_W-2:0]         shifted [3];

	conv3_pkg::out_t                     obuf_q [conv3_pkg::OUT_DEPTH];
	logic [conv3_pkg::OUT_AW-1:0]        owr_q, ord_q;
	logic [conv3_pkg::OUT_AW:0]          ocnt_q, credit_q;
	logic                                out_xfer, reserve;

	assign op_pop   = !op_empty && (!op_data.emit || credit_q != '0);
	assign reserve  = op_pop && op_data.emit;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (op_pop) begin
			up_rd_s1 <= upper_mem[op_data.xi];
			lo_rd_s1 <= lower_mem[op_data.xi];
			op_s1    <= op_data;
		end
		if (valid_s1) begin
			upper_mem[op_s1.xi] <= col[1];
			lower_mem[op_s1.xi] <= op_s1.pix;
			wr_addr_q <= op_s1.xi;
			wr_up_q   <= col[1];
			wr_lo_q   <= op_s1.pix;
		end
	end

	assign fwd = wr_valid_q && (wr_addr_q == op_s1.xi);

	always_comb begin
		col[0] = fwd ? wr_up_q : up_rd_s1;
		col[1] = fwd ? wr_lo_q : lo_rd_s1;
		col[2] = op_s1.pix;
		for (int r = 0; r < 3; r++) begin
			if (op_s1.first) begin
				nb[r*3+0]    = win_q[r*3+1];
				nb[r*3+1]    = win_q[r*3+2];
				nb[r*3+2]    = win_q[r*3+2];
				win_d[r*3+0] = col[r];
				win_d[r*3+1] = col[r];
				win_d[r*3+2] = col[r];
			end else begin
				win_d[r*3+0] = win_q[r*3+1];
				win_d[r*3+1] = win_q[r*3+2];
				win_d[r*3+2] = col[r];
				nb[r*3+0]    = win_d[r*3+0];
				nb[r*3+1]    = win_d[r*3+1];
				nb[r*3+2]    = win_d[r*3+2];
			end
		end
		// replicate the middle row over the frame's top and bottom edge
		if (op_s1.top) begin
			for (int c = 0; c < 3; c++) nb[c] = nb[3+c];
		end
		if (op_s1.bot) begin
			for (int c = 0; c < 3; c++) nb[6+c] = nb[3+c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (valid_s1) begin
			for (int i = 0; i < 9; i++) win_q[i] <= win_d[i];
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (valid_s1 && op_s1.emit) begin
			for (int i = 0; i < 9; i++) nb_s2[i] <= nb[i];
			last_s2 <= op_s1.last;
		end
		if (valid_s2) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 0; i < 9; i++) begin
					prod_s3[ch][i] <=
						conv3_pkg::PROD_W'(signed'(cfg.kernel[i/3][8*(i%3) +: 8]))
						* conv3_pkg::PROD_W'(signed'({1'b0, nb_s2[i][8*ch +: 8]}));
				end
			end
			last_s3 <= last_s2;
		end
		if (valid_s3) begin
			for (int ch = 0; ch < 3; ch++) sum_s4[ch] <= sum_d[ch];
			last_s4 <= last_s3;
		end
		if (valid_s4) begin
			obuf_q[owr_q] <= res;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_d[ch] = '0;
			for (int i = 0; i < 9; i++)
				sum_d[ch] = sum_d[ch] + conv3_pkg::SUM_W'(prod_s3[ch][i]);
		end
	end

	always_comb begin
		res.last = last_s4;
		for (int ch = 0; ch < 3; ch++) begin
			shifted[ch] = sum_s4[ch][conv3_pkg::SUM_W-2:0] >> cfg.shift;
			if (sum_s4[ch][conv3_pkg::SUM_W-1])
				res.pix[8*ch +: 8] = 8'd0;
			else if (shifted[ch] > (conv3_pkg::SUM_W-1)'(255))
				res.pix[8*ch +: 8] = 8'd255;
			else
				res.pix[8*ch +: 8] = shifted[ch][7:0];
		end
	end

	assign out_valid = (ocnt_q != '0);
	assign out_data  = obuf_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			valid_s4   <= 1'b0;
			wr_valid_q <= 1'b0;
			owr_q      <= '0;
			ord_q      <= '0;
			ocnt_q     <= '0;
			credit_q   <= (conv3_pkg::OUT_AW+1)'(conv3_pkg::OUT_DEPTH);
		end else begin
			valid_s1 <= op_pop;
			valid_s2 <= valid_s1 && op_s1.emit;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (valid_s1) wr_valid_q <= 1'b1;
			if (valid_s4) owr_q <= owr_q + 1'b1;
			if (out_xfer) ord_q <= ord_q + 1'b1;
			if (valid_s4 && !out_xfer)      ocnt_q <= ocnt_q + 1'b1;
			else if (out_xfer && !valid_s4) ocnt_q <= ocnt_q - 1'b1;
			if (reserve && !out_xfer)      credit_q <= credit_q - 1'b1;
			else if (out_xfer && !reserve) credit_q <= credit_q + 1'b1;
		end
	end

endmodule
